### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/dktm_pkg.sv
// Types and constants for the debounced key tuning menu
`timescale 1ns / 1ps
package dktm_pkg;

  localparam int KEY_COUNT  = 4;
  localparam int GAIN_COUNT = 5;
  localparam int GAIN_W     = 16;
  localparam int SPEED_STEP = 10;
  localparam int SPEED_CAP_W = 9;

  // key lanes
  localparam int KEY_CLEAR = 0;
  localparam int KEY_MENU  = 1;
  localparam int KEY_ADD   = 2;
  localparam int KEY_SUB   = 3;

  // menu items
  localparam logic [2:0] ITEM_RUN        = 3'd0;
  localparam logic [2:0] ITEM_SPEED      = 3'd1;
  localparam logic [2:0] ITEM_GAIN_FIRST = 3'd2;
  localparam logic [2:0] ITEM_LAST       = 3'd6;

  // run command codes
  localparam logic [1:0] RUN_NONE  = 2'd0;
  localparam logic [1:0] RUN_START = 2'd1;
  localparam logic [1:0] RUN_STOP  = 2'd2;

  // beep codes
  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_PAIR = 2'd1;
  localparam logic [1:0] BEEP_TRIO = 2'd2;

  typedef struct packed {
    logic [KEY_COUNT-1:0] press;  // raw pressed this tick
    logic [KEY_COUNT-1:0] fire;   // new stable press
  } key_ev_t;

  typedef struct packed {
    logic [GAIN_COUNT-1:0][GAIN_W-1:0] gain;
    logic [SPEED_CAP_W-1:0]            speed_cap;
    logic [2:0]                        menu_index;
    logic [1:0]                        beep;
    logic [1:0]                        run;
  } menu_result_t;

endpackage

### hdl/dktm_debounce.sv
// Four-lane counter debouncer with press detection
`timescale 1ns / 1ps
module dktm_debounce
  import dktm_pkg::*;
#(
  parameter int DEBOUNCE_SAMPLES = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [KEY_COUNT-1:0] level,
  output key_ev_t              ev
);

  localparam int CNT_W = $clog2(DEBOUNCE_SAMPLES + 1);

  logic [KEY_COUNT-1:0]            stable, stable_next;
  logic [KEY_COUNT-1:0]            last, last_next;
  logic [KEY_COUNT-1:0][CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0]                bumped;

  always_comb begin
    stable_next = stable;
    last_next   = last;
    count_next  = count;
    bumped      = '0;
    ev.press    = ~level;
    ev.fire     = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (ev.press[k] != last[k]) begin
        last_next[k]  = ev.press[k];
        count_next[k] = CNT_W'(1);
      end else begin
        bumped = (count[k] < CNT_W'(DEBOUNCE_SAMPLES)) ? count[k] + CNT_W'(1) : count[k];
        count_next[k] = bumped;
        if (bumped >= CNT_W'(DEBOUNCE_SAMPLES) && stable[k] != ev.press[k]) begin
          stable_next[k] = ev.press[k];
          ev.fire[k]     = ev.press[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= '0;
      last   <= '0;
      count  <= '0;
    end else if (step) begin
      stable <= stable_next;
      last   <= last_next;
      count  <= count_next;
    end
  end

endmodule

### hdl/dktm_menu.sv
// Menu state: item index, speed limit, gains and their default registers
`timescale 1ns / 1ps
module dktm_menu
  import dktm_pkg::*;
#(
  parameter int SPEED_MAX = 400
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  key_ev_t           ev,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [GAIN_W-1:0] cfg_data,
  output menu_result_t      res
);

  localparam int SPEED_W = $clog2(SPEED_MAX + 1);

  logic [GAIN_COUNT-1:0][GAIN_W-1:0] dflt;
  logic [GAIN_COUNT-1:0][GAIN_W-1:0] gain, gain_next;
  logic [2:0]                        item, item_next;
  logic [SPEED_W-1:0]                speed, speed_next;
  logic [SPEED_W:0]                  speed_up;
  logic [SPEED_W+SPEED_CAP_W-1:0]    speed_ext;
  logic                              up;

  assign speed_up  = {1'b0, speed} + (SPEED_W + 1)'(SPEED_STEP);
  assign speed_ext = {{SPEED_CAP_W{1'b0}}, speed_next};
  assign up        = ev.fire[KEY_ADD];

  always_comb begin
    gain_next  = gain;
    item_next  = item;
    speed_next = speed;
    res.run    = RUN_NONE;
    res.beep   = BEEP_NONE;
    if (ev.fire[KEY_CLEAR]) begin
      res.run    = RUN_STOP;
      res.beep   = BEEP_TRIO;
      speed_next = '0;
      item_next  = ITEM_RUN;
      gain_next  = dflt;
    end else if (ev.fire[KEY_MENU]) begin
      item_next = (item >= ITEM_LAST) ? ITEM_RUN : item + 3'd1;
      res.beep  = BEEP_PAIR;
    end else if (ev.press[KEY_ADD] && ev.press[KEY_SUB]) begin
      // both adjust keys held: no action
    end else if (ev.fire[KEY_ADD] || ev.fire[KEY_SUB]) begin
      res.beep = BEEP_PAIR;
      if (item == ITEM_RUN) begin
        res.run = up ? RUN_START : RUN_STOP;
      end else if (item == ITEM_SPEED) begin
        if (up) begin
          speed_next = (speed_up > (SPEED_W + 1)'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
                                                              : speed_up[SPEED_W-1:0];
        end else begin
          speed_next = (speed < SPEED_W'(SPEED_STEP)) ? '0 : speed - SPEED_W'(SPEED_STEP);
        end
      end else begin
        for (int g = 0; g < GAIN_COUNT; g++) begin
          if (item == ITEM_GAIN_FIRST + 3'(g)) begin
            if (up && gain[g] != '1) begin
              gain_next[g] = gain[g] + GAIN_W'(1);
            end else if (!up && gain[g] != '0) begin
              gain_next[g] = gain[g] - GAIN_W'(1);
            end
          end
        end
      end
    end
    res.gain       = gain_next;
    res.menu_index = item_next;
    res.speed_cap  = speed_ext[SPEED_CAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt  <= '0;
      gain  <= '0;
      item  <= ITEM_RUN;
      speed <= '0;
    end else begin
      if (cfg_we && cfg_index < 3'(GAIN_COUNT)) begin
        dflt[cfg_index] <= cfg_data;
      end
      if (step) begin
        gain  <= gain_next;
        item  <= item_next;
        speed <= speed_next;
      end
    end
  end

endmodule

### hdl/debounced_key_tuning_menu.sv
// Top level: key sampling stream in, menu status stream out
`timescale 1ns / 1ps
// Usage:
//   Each word on the s_axis channel is one sampling tick of four active-low
//   keys (reset, menu, add, sub). For every word taken, exactly one status
//   word leaves on m_axis: run command, beep pattern, menu index, speed
//   limit and five gains, all as they stand after that tick.
//   Gain defaults are loaded through cfg_we/cfg_index/cfg_data; they take
//   effect at the next reset key press. Write them while the block is idle.
//   The status word is registered: it is valid in the cycle after its key
//   word is taken. Throughput: one word per cycle unless m_axis stalls.
//   Debounce, event priority and the menu update form one combinational
//   pass between the state registers and the single output register.
//   Stall: while an output word waits on m_axis_tready, s_axis_tready is low;
//   it goes high again in the cycle the waiting word is taken.
//   Reset (rst, synchronous): debouncers, menu index, speed, gains and gain
//   defaults go to zero and the output register empties.
module debounced_key_tuning_menu
  import dktm_pkg::*;
#(
  parameter int DEBOUNCE_SAMPLES = 3,
  parameter int SPEED_MAX        = 400
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] reset_key_level, [1] menu_key_level, [2] add_key_level,
  // [3] sub_key_level, [7:4] zero
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] run_command, [3:2] beep_pattern, [6:4] menu_index,
  // [15:7] speed_cap, [31:16] gain_one, [47:32] gain_two,
  // [63:48] gain_three, [79:64] integral_gain, [95:80] derivative_gain
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "assert_macros.svh"

  key_ev_t      ev;
  menu_result_t res;
  menu_result_t out_word;
  logic         take;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  dktm_debounce #(
    .DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
  ) u_debounce (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .level(s_axis_tdata[KEY_COUNT-1:0]),
    .ev   (ev)
  );

  dktm_menu #(
    .SPEED_MAX(SPEED_MAX)
  ) u_menu (
    .clk      (clk),
    .rst      (rst),
    .step     (take),
    .ev       (ev),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = {out_word.gain[4], out_word.gain[3], out_word.gain[2],
                         out_word.gain[1], out_word.gain[0], out_word.speed_cap,
                         out_word.menu_index, out_word.beep, out_word.run};

  `ASSERT_NEXT(a_take_gives_word, clk, rst, take, m_axis_tvalid)
  `ASSERT_SAME(a_no_overwrite, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `ASSERT_SAME(a_index_range, clk, rst, m_axis_tvalid, out_word.menu_index <= ITEM_LAST)
  `ASSERT_SAME(a_trio_is_stop, clk, rst, m_axis_tvalid && out_word.beep == BEEP_TRIO,
               out_word.run == RUN_STOP)

endmodule
